/* hdl/aesd_pkg.sv */
// ----------------------------------------------------------------------------
// aesd_pkg
// Shared tables and GF(2^8) helpers for the AES-128 decryption pipeline.
// ----------------------------------------------------------------------------
package aesd_pkg;

	typedef logic [7:0] byte_tab_t [256];

	localparam int NumRounds = 10;
	localparam logic [0:0] REG_KEY_HIGH = 1'b0;
	localparam logic [0:0] REG_KEY_LOW  = 1'b1;
	localparam logic [7:0] RCON_FIRST   = 8'h01;
	localparam logic [8:0] GF_POLY      = 9'h11B;

	localparam byte_tab_t INV_SUB_TAB = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
	};

	function automatic byte_tab_t build_fwd_sbox();
		byte_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[INV_SUB_TAB[i]] = 8'(i);
		end
		return t;
	endfunction

	localparam byte_tab_t FWD_SBOX = build_fwd_sbox();

	function automatic logic [7:0] xtime(input logic [7:0] b);
		logic [8:0] v;
		v = {b, 1'b0};
		if (v[8]) begin
			v = v ^ GF_POLY;
		end
		return v[7:0];
	endfunction

	function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m9 [4];
		logic [7:0] m11 [4];
		logic [7:0] m13 [4];
		logic [7:0] m14 [4];
		for (int i = 0; i < 4; i++) begin
			a[i]   = col[31-8*i -: 8];
			a2[i]  = xtime(a[i]);
			a4[i]  = xtime(a2[i]);
			a8[i]  = xtime(a4[i]);
			m9[i]  = a8[i] ^ a[i];
			m11[i] = a8[i] ^ a2[i] ^ a[i];
			m13[i] = a8[i] ^ a4[i] ^ a[i];
			m14[i] = a8[i] ^ a4[i] ^ a2[i];
		end
		return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
		        m9[0] ^ m14[1] ^ m11[2] ^ m13[3],
		        m13[0] ^ m9[1] ^ m14[2] ^ m11[3],
		        m11[0] ^ m13[1] ^ m9[2] ^ m14[3]};
	endfunction

endpackage

/* hdl/aesd_key_sched.sv */
// ----------------------------------------------------------------------------
// aesd_key_sched
// Holds the cipher key and expands it into eleven round keys, one per cycle.
// ----------------------------------------------------------------------------
module aesd_key_sched (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [1:0]          wr_index,
	input  logic [63:0]         wr_data,
	output logic                running,
	output logic [10:0][127:0]  round_keys
);
	import aesd_pkg::*;

	logic [63:0]        key_high_q;
	logic [63:0]        key_low_q;
	logic               run_q;
	logic [3:0]         cnt_q;
	logic [7:0]         rcon_q;
	logic [10:1][127:0] rk_q;
	logic [127:0]       prev_key;
	logic [127:0]       next_key;
	logic [31:0]        tmp_word;

	always_comb begin
		prev_key = (cnt_q == 4'd0) ? {key_high_q, key_low_q} : rk_q[cnt_q];
		tmp_word = {FWD_SBOX[prev_key[23:16]] ^ rcon_q, FWD_SBOX[prev_key[15:8]],
		            FWD_SBOX[prev_key[7:0]], FWD_SBOX[prev_key[31:24]]};
		next_key[127:96] = prev_key[127:96] ^ tmp_word;
		next_key[95:64]  = prev_key[95:64] ^ next_key[127:96];
		next_key[63:32]  = prev_key[63:32] ^ next_key[95:64];
		next_key[31:0]   = prev_key[31:0] ^ next_key[63:32];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			run_q      <= 1'b1;
			cnt_q      <= '0;
			rcon_q     <= RCON_FIRST;
		end else if (wr_en) begin
			if (wr_index == {1'b0, REG_KEY_HIGH}) begin
				key_high_q <= wr_data;
			end
			if (wr_index == {1'b0, REG_KEY_LOW}) begin
				key_low_q <= wr_data;
			end
			run_q  <= 1'b1;
			cnt_q  <= '0;
			rcon_q <= RCON_FIRST;
		end else if (run_q) begin
			rcon_q <= xtime(rcon_q);
			if (cnt_q == 4'(NumRounds - 1)) begin
				run_q <= 1'b0;
			end
			cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_q && !wr_en) begin
			rk_q[cnt_q + 4'd1] <= next_key;
		end
	end

	assign running = run_q;
	always_comb begin
		round_keys[0] = {key_high_q, key_low_q};
		for (int i = 1; i <= NumRounds; i++) begin
			round_keys[i] = rk_q[i];
		end
	end

endmodule

/* hdl/aesd_round.sv */
// ----------------------------------------------------------------------------
// aesd_round
// One registered inverse round: shift rows, S-box, key add, mix columns (skipped in the last round).
// ----------------------------------------------------------------------------
module aesd_round (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         last_round,
	input  logic         in_valid,
	input  logic [127:0] in_state,
	input  logic [127:0] round_key,
	output logic         out_valid,
	output logic [127:0] out_state
);
	import aesd_pkg::*;

	logic [127:0] shifted;
	logic [127:0] keyed;
	logic [127:0] mixed;
	logic         valid_s1;
	logic [127:0] state_s1;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				shifted[127 - 8*(4*((c + r) % 4) + r) -: 8] =
					INV_SUB_TAB[in_state[127 - 8*(4*c + r) -: 8]];
			end
		end
		keyed = shifted ^ round_key;
		for (int c = 0; c < 4; c++) begin
			mixed[127 - 32*c -: 32] = inv_mix_col(keyed[127 - 32*c -: 32]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		state_s1 <= last_round ? keyed : mixed;
	end

	assign out_valid = valid_s1;
	assign out_state = state_s1;

endmodule

/* hdl/aes128_block_decrypt.sv */
// ----------------------------------------------------------------------------
// aes128_block_decrypt
// AES-128 inverse cipher, one round per pipeline stage.
//
//   channel   handshake             payload
//   block in  start / busy          cipher_high, cipher_low
//   block out done (strobe)         plain_high, plain_low
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One block per cycle while busy is low; each accepted block passes through
// the key-add stage and then ten round stages before done is raised.
// After reset and after each key write, busy is high while
// the key schedule expands, one round key per cycle.
// The output cannot be stalled; the pipeline always advances.
// ----------------------------------------------------------------------------
module aes128_block_decrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	output logic        done,
	output logic [63:0] plain_high,
	output logic [63:0] plain_low,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import aesd_pkg::*;

	logic                 key_busy;
	logic [10:0][127:0]   round_keys;
	logic                 valid_s0;
	logic [127:0]         state_s0;
	logic [NumRounds:0]   stage_valid;
	logic [NumRounds:0][127:0] stage_state;

	assign cfg_ready = 1'b1;
	assign busy      = key_busy;

	aesd_key_sched u_key_sched (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && cfg_ready),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.running    (key_busy),
		.round_keys (round_keys)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else begin
			valid_s0 <= start && !key_busy;
		end
	end

	always_ff @(posedge clk) begin
		state_s0 <= {cipher_high, cipher_low} ^ round_keys[NumRounds];
	end

	assign stage_valid[0] = valid_s0;
	assign stage_state[0] = state_s0;

	for (genvar k = 1; k <= NumRounds; k++) begin : g_round
		aesd_round u_round (
			.clk        (clk),
			.arst_n     (arst_n),
			.last_round (k == NumRounds),
			.in_valid   (stage_valid[k-1]),
			.in_state   (stage_state[k-1]),
			.round_key  (round_keys[NumRounds - k]),
			.out_valid  (stage_valid[k]),
			.out_state  (stage_state[k])
		);
	end

	assign done       = stage_valid[NumRounds];
	assign plain_high = stage_state[NumRounds][127:64];
	assign plain_low  = stage_state[NumRounds][63:0];

endmodule

/* hdl/aesd_checker.sv */
// ----------------------------------------------------------------------------
// aesd_checker
// Port-level checks on the decryption pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module aesd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##11 done)
		else $error("accepted beat did not come out after 11 cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 11))
		else $error("result beat without matching input beat");

	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> busy)
		else $error("key write did not start key expansion");

	a_busy_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> ##9 busy)
		else $error("key expansion ended early");

endmodule

bind aes128_block_decrypt aesd_checker u_aesd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
